>>> sv/rgbacm_pkg.sv
// Package: pixel word types, register indexes, sRGB conversion tables and row arithmetic.
package rgbacm_pkg;

	localparam int unsigned RowW  = 64;
	localparam int unsigned WgtW  = 12;
	localparam int unsigned OffW  = 16;
	localparam int unsigned AccW  = 24;
	localparam int unsigned BigW  = 256;

	typedef enum logic [1:0] {
		REG_RED   = 2'd0,
		REG_GREEN = 2'd1,
		REG_BLUE  = 2'd2,
		REG_ALPHA = 2'd3
	} reg_index_t;

	localparam logic [RowW-1:0] RedRowRst   = 64'd256;
	localparam logic [RowW-1:0] GreenRowRst = 64'd1048576;
	localparam logic [RowW-1:0] BlueRowRst  = 64'd4294967296;
	localparam logic [RowW-1:0] AlphaRowRst = 64'd17592186044416;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       write_pixel;
	} pixel_out_t;

	typedef logic [255:0][7:0] rom_t;

	function automatic logic [BigW-1:0] big_pow(input logic [BigW-1:0] b, input int unsigned e);
		logic [BigW-1:0] r;
		r = BigW'(1);
		for (int unsigned k = 0; k < e; k++) begin
			r = r * b;
		end
		return r;
	endfunction

	// sRGB code to 8-bit linear, rounded half up; exact integer form of the curve test
	function automatic rom_t build_to_lin();
		rom_t            r;
		logic [BigW-1:0] p12;
		logic [BigW-1:0] lhs;
		logic [BigW-1:0] rhs;
		int unsigned     n;
		bit              done;
		p12 = big_pow(BigW'(10761), 12);
		n = 0;
		for (int unsigned i = 0; i < 256; i++) begin
			if (i <= 10) begin
				while (n < 255 && (2 * (n + 1) - 1) * 1292 <= 200 * i) begin
					n++;
				end
			end else begin
				if (i == 11) begin
					n = 0;
				end
				rhs = big_pow(BigW'(510), 5) * big_pow(BigW'(40 * i + 561), 12);
				done = 1'b0;
				while (n < 255 && !done) begin
					lhs = p12 * big_pow(BigW'(2 * (n + 1) - 1), 5);
					if (lhs > rhs) begin
						done = 1'b1;
					end else begin
						n++;
					end
				end
			end
			r[i] = n[7:0];
		end
		return r;
	endfunction

	// 8-bit linear to sRGB code, ties round up
	function automatic rom_t build_from_lin();
		rom_t            r;
		logic [BigW-1:0] p12;
		logic [BigW-1:0] lhs;
		logic [BigW-1:0] rhs;
		int unsigned     n;
		bit              done;
		p12 = big_pow(BigW'(10761), 12);
		r[0] = 8'd0;
		n = 0;
		for (int unsigned i = 1; i < 256; i++) begin
			rhs = p12 * big_pow(BigW'(i), 5);
			done = 1'b0;
			while (n < 255 && !done) begin
				lhs = big_pow(BigW'(255), 5) * big_pow(BigW'(40 * (n + 1) + 541), 12);
				if (lhs > rhs) begin
					done = 1'b1;
				end else begin
					n++;
				end
			end
			r[i] = n[7:0];
		end
		return r;
	endfunction

	localparam rom_t ToLin   = build_to_lin();
	localparam rom_t FromLin = build_from_lin();

	// One matrix row: four Q3.8 weights, Q10.5 offset, round half up, clamp to 0..255
	function automatic logic [7:0] apply_row(
		input logic [RowW-1:0] row,
		input logic [7:0]      v0,
		input logic [7:0]      v1,
		input logic [7:0]      v2,
		input logic [7:0]      v3
	);
		logic signed [AccW-1:0] acc;
		logic signed [WgtW-1:0] w0, w1, w2, w3;
		logic signed [OffW-1:0] off;
		w0  = row[0*WgtW +: WgtW];
		w1  = row[1*WgtW +: WgtW];
		w2  = row[2*WgtW +: WgtW];
		w3  = row[3*WgtW +: WgtW];
		off = row[RowW-1 -: OffW];
		// widen both factors first so each product is formed at full width
		acc = AccW'(w0) * $signed(AccW'(v0)) + AccW'(w1) * $signed(AccW'(v1))
			+ AccW'(w2) * $signed(AccW'(v2)) + AccW'(w3) * $signed(AccW'(v3))
			+ (AccW'(off) <<< 3) + AccW'(128);
		if (acc[AccW-1]) begin
			return 8'd0;
		end else if (|acc[AccW-2:16]) begin
			return 8'd255;
		end else begin
			return acc[15:8];
		end
	endfunction

endpackage

>>> sv/rgba_colour_matrix_4x5_core.sv
// Top level: RGBA 4x5 colour matrix in linear light, up to one word per clock.
//
// Usage:
//   Input channel in_valid / in_ready / in_data carries one RGBA pixel word
//   (sRGB colour bytes, straight alpha). Output channel out_valid / out_ready
//   / out_data carries the transformed word; write_pixel is low, with all
//   bytes zero, when the input alpha was zero.
//   The four matrix rows are written through cfg_we / cfg_index / cfg_data
//   while no pixel is in flight; each row holds four signed Q3.8 weights in
//   bits 0-47 and a signed Q10.5 offset in bits 48-63.
//   A word accepted into the input register passes through the matrix
//   arithmetic into the result register, which drives the output.
//   Throughput: one word per clock while the receiver takes words; the input
//   register and the result register form a two-stage pipeline, and all
//   matrix arithmetic sits between them.
//   Reset loads the identity matrix and empties both stages.
//   When the receiver holds out_ready low the result register holds its
//   word; the input stage takes one more word if it is empty, then
//   in_ready drops until the output is taken.
module rgba_colour_matrix_4x5_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  rgbacm_pkg::pixel_in_t  in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output rgbacm_pkg::pixel_out_t out_data,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [63:0]            cfg_data
);
	import rgbacm_pkg::*;

	logic [RowW-1:0] red_row_q, green_row_q, blue_row_q, alpha_row_q;
	logic            valid_s1, valid_s2;
	pixel_in_t       pixel_s1;
	pixel_out_t      pixel_s2;
	pixel_out_t      result;
	logic            en_s1, en_s2;
	logic [7:0]      lin_r, lin_g, lin_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_row_q   <= RedRowRst;
			green_row_q <= GreenRowRst;
			blue_row_q  <= BlueRowRst;
			alpha_row_q <= AlphaRowRst;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_RED:   red_row_q   <= cfg_data;
				REG_GREEN: green_row_q <= cfg_data;
				REG_BLUE:  blue_row_q  <= cfg_data;
				REG_ALPHA: alpha_row_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance each stage when the one after it has room
	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			pixel_s1 <= in_data;
		end
		if (en_s2 && valid_s1) begin
			pixel_s2 <= result;
		end
	end

	assign lin_r = ToLin[pixel_s1.red_in];
	assign lin_g = ToLin[pixel_s1.green_in];
	assign lin_b = ToLin[pixel_s1.blue_in];

	always_comb begin
		result = '0;
		if (pixel_s1.alpha_in != 8'd0) begin
			result.red_out   = FromLin[apply_row(red_row_q, lin_r, lin_g, lin_b,
				pixel_s1.alpha_in)];
			result.green_out = FromLin[apply_row(green_row_q, lin_r, lin_g, lin_b,
				pixel_s1.alpha_in)];
			result.blue_out  = FromLin[apply_row(blue_row_q, lin_r, lin_g, lin_b,
				pixel_s1.alpha_in)];
			result.alpha_out = apply_row(alpha_row_q, lin_r, lin_g, lin_b,
				pixel_s1.alpha_in);
			result.write_pixel = 1'b1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = pixel_s2;

	a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	a_write_follows_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && en_s2 |=> out_data.write_pixel == ($past(pixel_s1.alpha_in) != 8'd0))
		else $error("write_pixel does not follow input alpha");

	a_dropped_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.write_pixel |-> out_data.red_out == 8'd0
			&& out_data.green_out == 8'd0 && out_data.blue_out == 8'd0
			&& out_data.alpha_out == 8'd0)
		else $error("dropped word carries nonzero bytes");

endmodule

>>> tb/tb_rgba_colour_matrix_4x5_core.sv
// Self-checking testbench for the RGBA 4x5 colour matrix core, with its own linear-light pixel predictor.
`timescale 1ns / 1ps

module tb_rgba_colour_matrix_4x5_core;
	import rgbacm_pkg::*;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned PhaseWords = 150;
	localparam int unsigned PhaseCount = 7;

	// Expected pixel words, the matrix rows and the sRGB tables
	class colour_matrix_board;
		logic [7:0]  to_linear[256];
		logic [7:0]  from_linear[256];
		logic [63:0] rows[4];
		pixel_out_t  expected_pixels[$];
		int unsigned fail_count;

		function logic [255:0] wide_pow(int unsigned b, int unsigned e);
			logic [255:0] p;
			p = 256'd1;
			repeat (e) p = p * 256'(b);
			return p;
		endfunction

		function new();
			logic [255:0] k12;
			logic [255:0] c510;
			logic [255:0] c255;
			logic [255:0] rhs;
			logic [255:0] odd_pow[256];
			logic [255:0] step_pow[256];
			int unsigned  cnt;
			fail_count = 0;
			rows[REG_RED]   = 64'h0000_0000_0000_0100;
			rows[REG_GREEN] = 64'h0000_0000_0010_0000;
			rows[REG_BLUE]  = 64'h0000_0001_0000_0000;
			rows[REG_ALPHA] = 64'h0000_1000_0000_0000;
			k12  = wide_pow(10761, 12);
			c510 = wide_pow(510, 5);
			c255 = wide_pow(255, 5);
			for (int n = 1; n < 256; n++) begin
				odd_pow[n]  = k12 * wide_pow(2 * n - 1, 5);
				step_pow[n] = c255 * wide_pow(40 * n + 541, 12);
			end
			// count the linear codes whose midpoint lies at or below the curve
			for (int i = 0; i < 256; i++) begin
				cnt = 0;
				if (i <= 10) begin
					for (int n = 1; n < 256; n++)
						if ((2 * n - 1) * 1292 <= 200 * i) cnt++;
				end else begin
					rhs = c510 * wide_pow(40 * i + 561, 12);
					for (int n = 1; n < 256; n++)
						if (odd_pow[n] <= rhs) cnt++;
				end
				to_linear[i] = 8'(cnt);
			end
			from_linear[0] = 8'd0;
			for (int i = 1; i < 256; i++) begin
				cnt = 0;
				rhs = k12 * wide_pow(i, 5);
				for (int n = 1; n < 256; n++)
					if (step_pow[n] <= rhs) cnt++;
				from_linear[i] = 8'(cnt);
			end
		endfunction

		function logic [7:0] row_value(logic [63:0] row, int v[4]);
			int                 acc;
			logic signed [11:0] w;
			logic signed [15:0] off;
			acc = 128;
			for (int j = 0; j < 4; j++) begin
				w = row[12*j +: 12];
				acc += int'(w) * v[j];
			end
			off = row[63:48];
			acc += int'(off) * 8;
			if (acc < 0) return 8'd0;
			if (acc >= 65536) return 8'd255;
			return 8'(acc >>> 8);
		endfunction

		function pixel_out_t predict_pixel(pixel_in_t px);
			pixel_out_t r;
			int         lin[4];
			r = '0;
			if (px.alpha_in == 8'd0) return r;
			lin[0] = to_linear[px.red_in];
			lin[1] = to_linear[px.green_in];
			lin[2] = to_linear[px.blue_in];
			lin[3] = px.alpha_in;
			r.red_out     = from_linear[row_value(rows[REG_RED], lin)];
			r.green_out   = from_linear[row_value(rows[REG_GREEN], lin)];
			r.blue_out    = from_linear[row_value(rows[REG_BLUE], lin)];
			r.alpha_out   = row_value(rows[REG_ALPHA], lin);
			r.write_pixel = 1'b1;
			return r;
		endfunction

		task note_source(pixel_in_t px);
			expected_pixels.push_back(predict_pixel(px));
		endtask

		task report(string what);
			$display("[%0t] mismatch: %s", $time, what);
			fail_count++;
		endtask

		task check_result(pixel_out_t got);
			pixel_out_t want;
			if (expected_pixels.size() == 0) begin
				report($sformatf("result word %h with nothing pending", got));
				return;
			end
			want = expected_pixels.pop_front();
			if (got.red_out != want.red_out)
				report($sformatf("red_out got %0d want %0d", got.red_out, want.red_out));
			if (got.green_out != want.green_out)
				report($sformatf("green_out got %0d want %0d", got.green_out, want.green_out));
			if (got.blue_out != want.blue_out)
				report($sformatf("blue_out got %0d want %0d", got.blue_out, want.blue_out));
			if (got.alpha_out != want.alpha_out)
				report($sformatf("alpha_out got %0d want %0d", got.alpha_out, want.alpha_out));
			if (got.write_pixel != want.write_pixel)
				report($sformatf("write_pixel got %0d want %0d", got.write_pixel,
					want.write_pixel));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	pixel_in_t   in_data;
	logic        out_valid;
	logic        out_ready;
	pixel_out_t  out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	colour_matrix_board board;
	int unsigned        src_gap_pct;
	int unsigned        sink_stall_pct;
	int unsigned        cycle_count = 0;

	rgba_colour_matrix_4x5_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_data);
	end

	// Receiver: random stall bursts
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_stall_pct != 0 && $urandom_range(1, 100) <= sink_stall_pct) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	function automatic pixel_in_t pix(int r, int g, int b, int a);
		pixel_in_t p;
		p.red_in   = 8'(r);
		p.green_in = 8'(g);
		p.blue_in  = 8'(b);
		p.alpha_in = 8'(a);
		return p;
	endfunction

	function automatic logic [63:0] make_row(int w0, int w1, int w2, int w3, int off);
		return {16'(off), 12'(w3), 12'(w2), 12'(w1), 12'(w0)};
	endfunction

	function automatic logic [63:0] random_row();
		case ($urandom_range(0, 7))
			0: return {$urandom, $urandom};
			1: begin
				case ($urandom_range(0, 3))
					0: return 64'd0;
					1: return '1;
					2: return make_row(2047, 2047, 2047, 2047, 32767);
					default: return make_row(-2048, -2048, -2048, -2048, -32768);
				endcase
			end
			default: return make_row(int'($urandom_range(0, 768)) - 384,
				int'($urandom_range(0, 768)) - 384, int'($urandom_range(0, 768)) - 384,
				int'($urandom_range(0, 768)) - 384, int'($urandom_range(0, 8192)) - 4096);
		endcase
	endfunction

	function automatic pixel_in_t random_pixel();
		pixel_in_t p;
		p.red_in   = 8'($urandom);
		p.green_in = 8'($urandom);
		p.blue_in  = 8'($urandom);
		p.alpha_in = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		return p;
	endfunction

	function automatic int unsigned pick_rate();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	// Offer one word from a falling edge; return at the falling edge after it is taken
	task automatic push_pixel(input pixel_in_t px);
		if (src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = px;
		do @(posedge clk); while (!in_ready);
		board.note_source(px);
		@(negedge clk);
	endtask

	task automatic write_row(input reg_index_t idx, input logic [63:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		board.rows[idx] = val;
		@(negedge clk);
	endtask

	// Drain the pipeline, then load all four rows
	task automatic write_matrix(input logic [63:0] r, input logic [63:0] g,
		input logic [63:0] b, input logic [63:0] a);
		in_valid = 1'b0;
		while (board.expected_pixels.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		write_row(REG_RED, r);
		write_row(REG_GREEN, g);
		write_row(REG_BLUE, b);
		write_row(REG_ALPHA, a);
		cfg_we = 1'b0;
	endtask

	initial begin
		board          = new();
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_we         = 1'b0;
		cfg_index      = REG_RED;
		cfg_data       = '0;
		src_gap_pct    = 20;
		sink_stall_pct = 20;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// identity matrix straight out of reset
		push_pixel(pix(0, 0, 0, 255));
		push_pixel(pix(255, 255, 255, 255));
		push_pixel(pix(128, 64, 32, 1));
		push_pixel(pix(200, 100, 50, 0));
		push_pixel(pix(10, 11, 12, 128));
		push_pixel(pix(170, 85, 170, 85));
		push_pixel(pix(85, 170, 85, 170));
		push_pixel(pix(1, 2, 3, 254));

		// every sum above full scale
		write_matrix(make_row(2047, 2047, 2047, 2047, 32767),
			make_row(2047, 2047, 2047, 2047, 32767),
			make_row(2047, 2047, 2047, 2047, 32767),
			make_row(2047, 2047, 2047, 2047, 32767));
		push_pixel(pix(0, 0, 0, 1));
		push_pixel(pix(255, 255, 255, 255));
		push_pixel(pix(255, 0, 255, 0));

		// every sum below zero
		write_matrix(make_row(-2048, -2048, -2048, -2048, -32768),
			make_row(-2048, -2048, -2048, -2048, -32768),
			make_row(-2048, -2048, -2048, -2048, -32768),
			make_row(-2048, -2048, -2048, -2048, -32768));
		push_pixel(pix(255, 255, 255, 255));
		push_pixel(pix(0, 0, 0, 1));

		// channel swap, all-ones, flat grey offset, all-zero
		write_matrix(make_row(0, 0, 256, 0, 0), '1, make_row(0, 0, 0, 0, 4096), 64'd0);
		push_pixel(pix(255, 128, 7, 255));
		push_pixel(pix(3, 250, 99, 17));
		push_pixel(pix(255, 255, 255, 255));
		push_pixel(pix(0, 0, 0, 0));

		for (int ph = 0; ph < PhaseCount; ph++) begin
			write_matrix(random_row(), random_row(), random_row(), random_row());
			if (ph == PhaseCount - 1) begin
				src_gap_pct    = 0;
				sink_stall_pct = 0;
			end else begin
				src_gap_pct    = pick_rate();
				sink_stall_pct = pick_rate();
			end
			repeat (PhaseWords) push_pixel(random_pixel());
		end

		in_valid = 1'b0;
		while (board.expected_pixels.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		if (board.fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
